// File: hw/rtl/simple_moving_average_defines.svh
// Assertion macros used by the moving average control FSM.
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average assertion failed");

`endif

// File: hw/rtl/sma_pkg.sv
package sma_pkg;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/sma_if.sv
interface sma_in_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] price;
    logic                          restart;

    modport source (output valid, price, restart, input ready);
    modport sink (input valid, price, restart, output ready);
endinterface

interface sma_out_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          window_full;

    modport source (output valid, average, window_full, input ready);
    modport sink (input valid, average, window_full, output ready);
endinterface

// File: hw/rtl/simple_moving_average.sv
// Channel   Port         Direction  Payload
// input     sample       sink       price, restart
// output    result       source     average, window_full
// config    cfg_wr_en    in         cfg_wr_data (window length)
//
// Each item runs through the read, update, start, divide and finish steps before the next is accepted.
// The divide step uses a restoring divider, which retires one quotient bit per cycle.
// A finished result waits in the output register while the next item is accepted.
// Reset clears the history and sets the window length to one; the ring needs no clearing.
// A stalled result holds the block in its last step until the result is taken.
module simple_moving_average #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [sma_pkg::CFG_W-1:0] cfg_wr_data,
    sma_in_if.sink                    sample,
    sma_out_if.source                 result
);

    sma_pkg::cmd_t    cmd;
    sma_pkg::status_t status;

    sma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sma_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_price        (sample.price),
        .in_restart      (sample.restart),
        .out_ready       (result.ready),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (result.valid),
        .out_average     (result.average),
        .out_window_full (result.window_full)
    );

endmodule

// File: hw/rtl/sma_divider.sv
module sma_divider #(
    parameter int TW    = 40,
    parameter int LEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [TW-1:0]    dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             busy,
    output logic [TW-1:0]    quotient
);

    localparam int CNT_W = $clog2(TW + 1);

    logic [TW-1:0]    q_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [LEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, q_reg[TW-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(TW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[TW-2:0], fits};
            if (fits)
            begin
                rem_reg <= LEN_W'(shifted - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= LEN_W'(shifted);
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/sma_datapath.sv
module sma_datapath #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sma_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0] in_price,
    input  logic                          in_restart,
    input  logic                          out_ready,
    input  sma_pkg::cmd_t                 cmd,
    output sma_pkg::status_t              status,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_average,
    output logic                          out_window_full
);

    localparam int PW    = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int TW    = SAMPLE_BITS + PW;
    localparam int CW    = (sma_pkg::CFG_W > LEN_W) ? sma_pkg::CFG_W : LEN_W;

    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

    logic [sma_pkg::CFG_W-1:0]     window_length_reg;
    logic [PW-1:0]                 wp_reg;
    logic                          filled_reg;
    logic signed [TW-1:0]          total_reg;
    logic                          out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] price_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic [LEN_W-1:0]              count_reg;
    logic                          neg_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic                          full_reg;

    logic [CW-1:0]                 cfg_wide;
    logic [LEN_W-1:0]              len;
    logic [PW-1:0]                 wp_base;
    logic [LEN_W-1:0]              pos_inc;
    logic signed [TW-1:0]          leaving;
    logic [TW-1:0]                 magnitude;
    logic                          div_busy;
    logic [TW-1:0]                 div_quot;
    logic [TW-1:0]                 quot_signed;

    always_comb
    begin
        cfg_wide = CW'(window_length_reg);
        if (cfg_wide == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_wide > CW'(WINDOW_MAX))
        begin
            len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len = LEN_W'(cfg_wide);
        end
    end

    assign wp_base     = in_restart ? '0 : wp_reg;
    assign pos_inc     = LEN_W'(wp_reg) + LEN_W'(1);
    assign leaving     = filled_reg ? TW'(rd_reg) : '0;
    assign magnitude   = total_reg[TW-1] ? TW'(0) - TW'(total_reg) : TW'(total_reg);
    assign quot_signed = neg_reg ? TW'(0) - div_quot : div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= sma_pkg::CFG_W'(1);
            wp_reg            <= '0;
            filled_reg        <= 1'b0;
            total_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_length_reg <= cfg_wr_data;
                wp_reg            <= '0;
                filled_reg        <= 1'b0;
                total_reg         <= '0;
            end
            else if (cmd.capture)
            begin
                if (in_restart)
                begin
                    total_reg <= '0;
                end
                if (LEN_W'(wp_base) >= len)
                begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    wp_reg     <= wp_base;
                    filled_reg <= filled_reg & ~in_restart;
                end
            end
            else if (cmd.update)
            begin
                total_reg <= total_reg - leaving + TW'(price_reg);
                if (pos_inc >= len)
                begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= PW'(pos_inc);
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            price_reg <= in_price;
        end
        if (cmd.read)
        begin
            rd_reg <= ring[wp_reg];
        end
        if (cmd.update)
        begin
            ring[wp_reg] <= price_reg;
            if (pos_inc >= len || filled_reg)
            begin
                count_reg <= len;
            end
            else
            begin
                count_reg <= pos_inc;
            end
        end
        if (cmd.div_start)
        begin
            neg_reg <= total_reg[TW-1];
        end
        if (cmd.out_load)
        begin
            average_reg <= $signed(quot_signed[SAMPLE_BITS-1:0]);
            full_reg    <= filled_reg;
        end
    end

    sma_divider #(
        .TW    (TW),
        .LEN_W (LEN_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (magnitude),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign status.div_done  = ~div_busy;
    assign status.out_free  = ~out_valid_reg | out_ready;
    assign out_valid        = out_valid_reg;
    assign out_average      = average_reg;
    assign out_window_full  = full_reg;

endmodule

// File: hw/rtl/sma_ctrl.sv
`include "simple_moving_average_defines.svh"

module sma_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sma_pkg::status_t status,
    output sma_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_START  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_START;
            ST_START:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready      = state_reg == ST_IDLE;
    assign cmd.capture   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.read      = state_reg == ST_READ;
    assign cmd.update    = state_reg == ST_UPDATE;
    assign cmd.div_start = state_reg == ST_START;
    assign cmd.out_load  = (state_reg == ST_FINISH) && status.out_free;

    `SMA_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state_reg == ST_READ)
    `SMA_ASSERT_NOW(a_load_free, cmd.out_load, status.out_free)
    `SMA_ASSERT_NEXT(a_div_runs, cmd.div_start, !status.div_done)

endmodule
